// ----- src/nearest_point_in_sector_assert.svh -----
// Assertion macros for the nearest point finder. Each expects aclk and
// aresetn in scope.
`ifndef NEAREST_POINT_IN_SECTOR_ASSERT_SVH
`define NEAREST_POINT_IN_SECTOR_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define NPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// State right after a reset cycle.
`define NPS_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

// ----- src/nps_pkg.sv -----
package nps_pkg;

    localparam int COORD_BITS    = 16;
    localparam int VEL_BITS      = 16;
    localparam int HALF_BITS     = 15;
    localparam int RANGE_BITS    = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CORDIC_STEPS  = 26;
    localparam int Z_BITS        = 32;
    // Vector width inside the rotation cells: room for the CORDIC gain.
    localparam int CW            = COORD_BITS + 3;
    localparam int HW            = VEL_BITS + 3;
    localparam int SQ_W          = 2 * COORD_BITS;

    localparam logic [Z_BITS-1:0] Z_HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [Z_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014
    };

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VEL_X      = 2'd0,
        REG_VEL_Y      = 2'd1,
        REG_HALF_ANGLE = 2'd2,
        REG_MAX_RANGE  = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         point_valid;
        logic                         last_point;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic                         found;
    } result_t;

    // Point data that rides alongside the rotation cells
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         point_valid;
        logic                         last_point;
        logic                         bear_zero;
        logic                         head_zero;
        logic [SQ_W-1:0]              sq_x;
        logic [SQ_W-1:0]              sq_y;
    } side_t;

    // What leaves the end of the cell row
    typedef struct packed {
        logic              valid;
        side_t             side;
        logic [Z_BITS-1:0] bear_z;
        logic [Z_BITS-1:0] head_z;
    } tail_t;

endpackage

// ----- src/nps_cordic_cell.sv -----
module nps_cordic_cell import nps_pkg::*; #(
    parameter int W    = 19,
    parameter int STEP = 0
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] u_i,
    input  logic signed [W-1:0] v_i,
    input  logic [Z_BITS-1:0]   z_i,
    output logic signed [W-1:0] u_o,
    output logic signed [W-1:0] v_o,
    output logic [Z_BITS-1:0]   z_o
);

    logic signed [W-1:0] u_reg, u_next;
    logic signed [W-1:0] v_reg, v_next;
    logic [Z_BITS-1:0]   z_reg, z_next;
    logic signed [W-1:0] u_sh, v_sh;

    always_comb begin
        u_sh = u_i >>> STEP;
        v_sh = v_i >>> STEP;
        // rotate toward the x axis
        if (!v_i[W-1]) begin
            u_next = u_i + v_sh;
            v_next = v_i - u_sh;
            z_next = z_i + ATAN_TAB[STEP];
        end else begin
            u_next = u_i - v_sh;
            v_next = v_i + u_sh;
            z_next = z_i - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg <= u_next;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    assign u_o = u_reg;
    assign v_o = v_reg;
    assign z_o = z_reg;

endmodule

// ----- src/nps_tracker.sv -----
module nps_tracker import nps_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  tail_t                 tail_i,
    input  logic [RANGE_BITS-1:0] max_range,
    input  logic [HALF_BITS-1:0]  half_angle,
    output logic                  res_valid,
    output result_t               res
);

    localparam int CMP_W  = (ANGLE_BITS > HALF_BITS) ? ANGLE_BITS : HALF_BITS;
    localparam int BEST_W = (SQ_W > 2 * RANGE_BITS) ? SQ_W : 2 * RANGE_BITS;
    localparam logic [Z_BITS-1:0] Z_ROUND = Z_BITS'(1) << (Z_BITS - 1 - ANGLE_BITS);

    logic [ANGLE_BITS-1:0] bear_ang, head_ang, diff, mag;
    logic [Z_BITS-1:0]     bear_zr, head_zr;
    logic                  in_sec;

    logic                         post_valid_reg;
    logic                         post_in_sec_reg;
    logic                         post_last_reg;
    logic [SQ_W-1:0]              post_dsq_reg;
    logic signed [COORD_BITS-1:0] post_x_reg, post_y_reg;
    logic [2*RANGE_BITS-1:0]      max_sq_reg;

    logic                         frame_open_reg, frame_open_next;
    logic                         best_found_reg, best_found_next;
    logic [BEST_W-1:0]            best_dist_reg, best_dist_next;
    logic signed [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic [BEST_W-1:0]            cur_dist;
    logic                         cur_found;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic                         take;

    // Round the turn fraction to the nearest step of the angle resolution.
    always_comb begin
        bear_zr  = tail_i.bear_z + Z_ROUND;
        head_zr  = tail_i.head_z + Z_ROUND;
        bear_ang = tail_i.side.bear_zero ? '0 : bear_zr[Z_BITS-1 -: ANGLE_BITS];
        head_ang = tail_i.side.head_zero ? '0 : head_zr[Z_BITS-1 -: ANGLE_BITS];
        diff     = bear_ang - head_ang;
        mag      = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
        in_sec   = tail_i.side.point_valid && (CMP_W'(mag) < CMP_W'(half_angle));
    end

    always_ff @(posedge aclk) begin
        max_sq_reg <= (2*RANGE_BITS)'(max_range) * (2*RANGE_BITS)'(max_range);
        if (en) begin
            post_in_sec_reg <= in_sec;
            post_last_reg   <= tail_i.side.last_point;
            post_dsq_reg    <= tail_i.side.sq_x + tail_i.side.sq_y;
            post_x_reg      <= tail_i.side.point_x;
            post_y_reg      <= tail_i.side.point_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_valid_reg <= 1'b0;
        end else if (en) begin
            post_valid_reg <= tail_i.valid;
        end
    end

    // Frame start loads the range limit in place of the held best.
    always_comb begin
        cur_dist  = frame_open_reg ? best_dist_reg : BEST_W'(max_sq_reg);
        cur_found = frame_open_reg && best_found_reg;
        cur_x     = frame_open_reg ? best_x_reg : '0;
        cur_y     = frame_open_reg ? best_y_reg : '0;
        take      = post_in_sec_reg && (BEST_W'(post_dsq_reg) < cur_dist);

        best_dist_next  = take ? BEST_W'(post_dsq_reg) : cur_dist;
        best_found_next = take || cur_found;
        best_x_next     = take ? post_x_reg : cur_x;
        best_y_next     = take ? post_y_reg : cur_y;
        frame_open_next = !post_last_reg;

        res_valid    = en && post_valid_reg && post_last_reg;
        res.found    = best_found_next;
        res.near_x   = best_found_next ? best_x_next : '0;
        res.near_y   = best_found_next ? best_y_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (en && post_valid_reg) begin
            best_dist_reg  <= best_dist_next;
            best_found_reg <= best_found_next;
            best_x_reg     <= best_x_next;
            best_y_reg     <= best_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
        end else if (en && post_valid_reg) begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

// ----- src/nearest_point_in_sector.sv -----
// Nearest point in a view sector. Points of a frame arrive one request at a
// time on s_*, the final one flagged by last_point; for each frame exactly one
// result leaves on m_*: the valid point nearest the origin whose bearing lies
// strictly within half_angle of the heading atan2(vel_x, vel_y) and whose
// squared distance is strictly below max_range squared, or zeros with found
// low. An earlier point wins a tie. Bearings come from two rows of 26 CORDIC
// cells (one for the point, one for the heading) that advance together, so
// the block takes one point per clock while s_ready is high. A result forms
// once the last point of its frame has passed the entry registers, the cell
// rows and the tracker. Two finished results can wait at the output; while
// both are held, s_ready drops and the whole row halts. Write the registers
// only while no frame is in flight; heading and sector width apply to every
// point, max_range is sampled at the first point of a frame.
module nearest_point_in_sector import nps_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  point_t                   s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output result_t                  m_data
);

    // configuration registers
    logic signed [VEL_BITS-1:0] vel_x_reg, vel_y_reg;
    logic [HALF_BITS-1:0]       half_angle_reg;
    logic [RANGE_BITS-1:0]      max_range_reg;

    // row advance: halt only when both output slots hold a result
    logic advance;

    // entry stage
    logic signed [CW-1:0]  px_w, py_w, pre_bu, pre_bv;
    logic signed [HW-1:0]  hx_w, hy_w, pre_hu, pre_hv;
    logic signed [SQ_W-1:0] sqx_w, sqy_w;
    side_t                  pre_side;

    // rotation rows and the side line that follows them
    logic signed [CW-1:0] bu [CORDIC_STEPS+1];
    logic signed [CW-1:0] bv [CORDIC_STEPS+1];
    logic [Z_BITS-1:0]    bz [CORDIC_STEPS+1];
    logic signed [HW-1:0] hu [CORDIC_STEPS+1];
    logic signed [HW-1:0] hv [CORDIC_STEPS+1];
    logic [Z_BITS-1:0]    hz [CORDIC_STEPS+1];

    logic signed [CW-1:0] bu0_reg, bv0_reg;
    logic [Z_BITS-1:0]    bz0_reg;
    logic signed [HW-1:0] hu0_reg, hv0_reg;
    logic [Z_BITS-1:0]    hz0_reg;
    side_t                side_reg  [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] valid_reg;

    tail_t   tail;
    logic    res_valid;
    result_t res;

    // output slots
    result_t     slot0_reg, slot1_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    // Register writes: take the low bits each register needs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            half_angle_reg <= HALF_BITS'(10923);
            max_range_reg  <= RANGE_BITS'(12000);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_VEL_X:      vel_x_reg      <= cfg_wdata[VEL_BITS-1:0];
                REG_VEL_Y:      vel_y_reg      <= cfg_wdata[VEL_BITS-1:0];
                REG_HALF_ANGLE: half_angle_reg <= cfg_wdata[HALF_BITS-1:0];
                REG_MAX_RANGE:  max_range_reg  <= cfg_wdata[RANGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign advance = (count_reg != 2'd2);
    assign s_ready = advance;

    // Entry: fold the left half plane over (start z at half a turn), flag
    // zero vectors, square the coordinates.
    always_comb begin
        px_w   = CW'(s_data.point_x);
        py_w   = CW'(s_data.point_y);
        pre_bu = px_w[CW-1] ? -px_w : px_w;
        pre_bv = px_w[CW-1] ? -py_w : py_w;

        hx_w   = HW'(vel_x_reg);
        hy_w   = HW'(vel_y_reg);
        pre_hu = hy_w[HW-1] ? -hy_w : hy_w;
        pre_hv = hy_w[HW-1] ? -hx_w : hx_w;

        sqx_w  = SQ_W'(s_data.point_x);
        sqy_w  = SQ_W'(s_data.point_y);

        pre_side.point_x     = s_data.point_x;
        pre_side.point_y     = s_data.point_y;
        pre_side.point_valid = s_data.point_valid;
        pre_side.last_point  = s_data.last_point;
        pre_side.bear_zero   = (s_data.point_x == '0) && (s_data.point_y == '0);
        pre_side.head_zero   = (vel_x_reg == '0) && (vel_y_reg == '0);
        pre_side.sq_x        = sqx_w * sqx_w;
        pre_side.sq_y        = sqy_w * sqy_w;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bu0_reg     <= pre_bu;
            bv0_reg     <= pre_bv;
            bz0_reg     <= px_w[CW-1] ? Z_HALF_TURN : '0;
            hu0_reg     <= pre_hu;
            hv0_reg     <= pre_hv;
            hz0_reg     <= hy_w[HW-1] ? Z_HALF_TURN : '0;
            side_reg[0] <= pre_side;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], s_valid};
        end
    end

    assign bu[0] = bu0_reg;
    assign bv[0] = bv0_reg;
    assign bz[0] = bz0_reg;
    assign hu[0] = hu0_reg;
    assign hv[0] = hv0_reg;
    assign hz[0] = hz0_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        nps_cordic_cell #(
            .W    (CW),
            .STEP (g)
        ) u_bear_cell (
            .aclk (aclk),
            .en   (advance),
            .u_i  (bu[g]),
            .v_i  (bv[g]),
            .z_i  (bz[g]),
            .u_o  (bu[g+1]),
            .v_o  (bv[g+1]),
            .z_o  (bz[g+1])
        );

        nps_cordic_cell #(
            .W    (HW),
            .STEP (g)
        ) u_head_cell (
            .aclk (aclk),
            .en   (advance),
            .u_i  (hu[g]),
            .v_i  (hv[g]),
            .z_i  (hz[g]),
            .u_o  (hu[g+1]),
            .v_o  (hv[g+1]),
            .z_o  (hz[g+1])
        );
    end

    // Only the angles leave the rows; the residual vectors are dropped.
    always_comb begin
        tail.valid  = valid_reg[CORDIC_STEPS];
        tail.side   = side_reg[CORDIC_STEPS];
        tail.bear_z = bz[CORDIC_STEPS];
        tail.head_z = hz[CORDIC_STEPS];
    end

    nps_tracker #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .tail_i     (tail),
        .max_range  (max_range_reg),
        .half_angle (half_angle_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Two-slot output queue; slot0 is the head.
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot0_reg;

    always_comb begin
        count_next = count_reg;
        if (res_valid && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !res_valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (res_valid) begin
                slot0_reg <= res;
            end else if (count_reg == 2'd2) begin
                slot0_reg <= slot1_reg;
            end
        end else if (res_valid) begin
            if (count_reg == 2'd0) begin
                slot0_reg <= res;
            end else begin
                slot1_reg <= res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/nps_checker.sv -----
`include "nearest_point_in_sector_assert.svh"

module nps_checker import nps_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    // no qualifying point means zero coordinates
    `NPS_ASSERT_IMP(a_empty_zero, m_valid && !m_data.found, m_data.near_x == '0 && m_data.near_y == '0, "result without a found point carries nonzero coordinates")

    // input is held off only while a result waits
    `NPS_ASSERT_IMP(a_stall_cause, !s_ready, m_valid, "input stalled with no result pending")

    // hold a stalled result
    `NPS_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result dropped or changed")

    // reset empties the output and opens the input
    `NPS_ASSERT_RST(a_reset_state, !m_valid && s_ready, "bad port state after reset")

endmodule

bind nearest_point_in_sector nps_checker u_nps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
